>>> rtl/rtss_pkg.sv
// Shared types and constants of the record table sort and search block.
`default_nettype none
package rtss_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SORT = 2'd1,
        OP_FIND = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_I   = 2'd0,
        RD_JM1 = 2'd1,
        RD_J   = 2'd2,
        RD_IDX = 2'd3
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_NONE  = 3'd0,
        RES_LOAD  = 3'd1,
        RES_OK    = 3'd2,
        RES_HIT   = 3'd3,
        RES_MISS  = 3'd4,
        RES_READ  = 3'd5,
        RES_RANGE = 3'd6
    } t_res;

    typedef struct packed {
        logic    latch;
        logic    do_load;
        logic    mem_rd;
        t_rd_sel rd_sel;
        logic    hold_k;
        logic    wr_shift;
        logic    wr_place;
        logic    sort_init;
        logic    find_init;
        logic    set_j_i;
        logic    inc_i;
        logic    inc_j;
        logic    dec_j;
        t_res    res;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic i_lt_cnt;
        logic j_lt_cnt;
        logic j_zero;
        logic rd_greater;
        logic rd_match;
        logic idx_ok;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/rtss_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface rtss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        start_new;
    logic signed [31:0] account_key;
    logic [31:0] payload_bits;
    logic [7:0]  entry_index;

    modport source (output valid, operation, start_new, account_key, payload_bits,
                    entry_index, input ready);
    modport sink (input valid, operation, start_new, account_key, payload_bits,
                  entry_index, output ready);
endinterface

interface rtss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  found_index;
    logic signed [31:0] key_out;
    logic [31:0] payload_out;
    logic [8:0]  entry_total;

    modport source (output valid, status, found_index, key_out, payload_out,
                    entry_total, input ready);
    modport sink (input valid, status, found_index, key_out, payload_out,
                  entry_total, output ready);
endinterface
`default_nettype wire

>>> rtl/record_table_sort_and_search.sv
// Top level of the record table sort and search block.
`default_nettype none
// A table of up to TABLE_DEPTH records, each a signed 32-bit key and 32 payload
// bits, kept in a single-port-write, single-port-read memory with registered
// read data. One request is worked at a time and gives one result. A load
// result is registered from the dispatch state and a read result after a
// further memory read state. Find alternates a read and a compare state per
// entry and stops at the first hit, or misses after all records. Sort is a
// stable insertion sort sequenced over the memory port: per record it reads
// the key, then reads and compares each left neighbour, shifting it right or
// placing the key. A new request is taken once the previous result has been
// transferred or is being transferred in that cycle.
module record_table_sort_and_search #(
    parameter int unsigned TABLE_DEPTH = rtss_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rtss_in_if.sink    i_in,
    rtss_out_if.source o_out
);
    import rtss_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ready;

    assign i_in.ready = ready;

    rtss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_ready    (ready)
    );

    rtss_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
`default_nettype wire

>>> rtl/rtss_ctrl.sv
// Sequencer for load, insertion sort, linear search and read.
`default_nettype none
module rtss_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire rtss_pkg::t_stat i_stat,
    output rtss_pkg::t_cmd      o_cmd,
    output logic                o_ready
);
    import rtss_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DISP = 9'b000000010,
        S_SI   = 9'b000000100,
        S_SK   = 9'b000001000,
        S_SJ   = 9'b000010000,
        S_SC   = 9'b000100000,
        S_FR   = 9'b001000000,
        S_FC   = 9'b010000000,
        S_RW   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_ready) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_LOAD: begin
                        o_cmd.do_load = 1'b1;
                        o_cmd.res     = RES_LOAD;
                        n_state       = S_IDLE;
                    end
                    OP_SORT: begin
                        o_cmd.sort_init = 1'b1;
                        n_state         = S_SI;
                    end
                    OP_FIND: begin
                        o_cmd.find_init = 1'b1;
                        n_state         = S_FR;
                    end
                    default: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.mem_rd = 1'b1;
                            o_cmd.rd_sel = RD_IDX;
                            n_state      = S_RW;
                        end else begin
                            o_cmd.res = RES_RANGE;
                            n_state   = S_IDLE;
                        end
                    end
                endcase
            end
            S_SI: begin
                if (i_stat.i_lt_cnt) begin
                    o_cmd.mem_rd  = 1'b1;
                    o_cmd.rd_sel  = RD_I;
                    o_cmd.set_j_i = 1'b1;
                    n_state       = S_SK;
                end else begin
                    o_cmd.res = RES_OK;
                    n_state   = S_IDLE;
                end
            end
            S_SK: begin
                o_cmd.hold_k = 1'b1;
                n_state      = S_SJ;
            end
            S_SJ: begin
                if (i_stat.j_zero) begin
                    o_cmd.wr_place = 1'b1;
                    o_cmd.inc_i    = 1'b1;
                    n_state        = S_SI;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_sel = RD_JM1;
                    n_state      = S_SC;
                end
            end
            S_SC: begin
                // A strictly greater left neighbor moves right; equal keys stop the walk.
                if (i_stat.rd_greater) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.dec_j    = 1'b1;
                    n_state        = S_SJ;
                end else begin
                    o_cmd.wr_place = 1'b1;
                    o_cmd.inc_i    = 1'b1;
                    n_state        = S_SI;
                end
            end
            S_FR: begin
                if (i_stat.j_lt_cnt) begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_sel = RD_J;
                    n_state      = S_FC;
                end else begin
                    o_cmd.res = RES_MISS;
                    n_state   = S_IDLE;
                end
            end
            S_FC: begin
                if (i_stat.rd_match) begin
                    o_cmd.res = RES_HIT;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.inc_j = 1'b1;
                    n_state     = S_FR;
                end
            end
            S_RW: begin
                o_cmd.res = RES_READ;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rtss_dp.sv
// Record memory, index registers, comparators and result register.
`default_nettype none
module rtss_dp #(
    parameter int unsigned TABLE_DEPTH = rtss_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rtss_in_if.sink         i_in,
    rtss_out_if.source      o_out,
    input  wire rtss_pkg::t_cmd i_cmd,
    output rtss_pkg::t_stat o_stat
);
    import rtss_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;
    localparam int unsigned XW = (CW > 8) ? CW : 8;

    logic [63:0] r_mem [TABLE_DEPTH];
    logic [63:0] r_rd;
    logic [63:0] r_k;

    t_op                r_op;
    logic               r_start;
    logic signed [31:0] r_key;
    logic [31:0]        r_pay;
    logic [7:0]         r_idx;
    logic [CW-1:0]      r_count, r_i, r_j;

    logic               r_valid;
    t_status            r_status;
    logic [7:0]         r_found;
    logic signed [31:0] r_kout;
    logic [31:0]        r_pout;
    logic [8:0]         r_total;

    logic [CW-1:0] base, load_count;
    logic          full;
    logic [CW-1:0] j_m1;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [63:0]   wr_data;
    logic          wr_en;

    assign base       = r_start ? '0 : r_count;
    assign full       = (base == CW'(TABLE_DEPTH));
    assign load_count = full ? base : base + CW'(1);
    assign j_m1       = r_j - CW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_I:    rd_addr = r_i[AW-1:0];
            RD_JM1:  rd_addr = j_m1[AW-1:0];
            RD_J:    rd_addr = r_j[AW-1:0];
            default: rd_addr = AW'(XW'(r_idx));
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_j[AW-1:0];
        wr_data = r_k;
        if (i_cmd.do_load) begin
            wr_en   = !full;
            wr_addr = base[AW-1:0];
            wr_data = {r_key, r_pay};
        end else if (i_cmd.wr_shift) begin
            wr_en   = 1'b1;
            wr_data = r_rd;
        end else if (i_cmd.wr_place) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= t_op'(i_in.operation);
            r_start <= i_in.start_new;
            r_key   <= i_in.account_key;
            r_pay   <= i_in.payload_bits;
            r_idx   <= i_in.entry_index;
        end
        if (i_cmd.hold_k) begin
            r_k <= r_rd;
        end
        if (i_cmd.sort_init) begin
            r_i <= CW'(1);
        end else if (i_cmd.inc_i) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.find_init) begin
            r_j <= '0;
        end else if (i_cmd.set_j_i) begin
            r_j <= r_i;
        end else if (i_cmd.inc_j) begin
            r_j <= r_j + CW'(1);
        end else if (i_cmd.dec_j) begin
            r_j <= j_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.do_load) begin
                r_count <= load_count;
            end
            if (i_cmd.res != RES_NONE) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res != RES_NONE) begin
            r_status <= ST_OK;
            r_found  <= '0;
            r_kout   <= '0;
            r_pout   <= '0;
            r_total  <= 9'(r_count);
            case (i_cmd.res)
                RES_LOAD: begin
                    r_status <= full ? ST_FULL : ST_OK;
                    r_total  <= 9'(load_count);
                end
                RES_HIT: begin
                    r_found <= 8'(XW'(r_j));
                end
                RES_MISS: begin
                    r_status <= ST_NOT_FOUND;
                end
                RES_READ: begin
                    r_kout <= r_rd[63:32];
                    r_pout <= r_rd[31:0];
                end
                RES_RANGE: begin
                    r_status <= ST_RANGE;
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.found_index = r_found;
    assign o_out.key_out     = r_kout;
    assign o_out.payload_out = r_pout;
    assign o_out.entry_total = r_total;

    assign o_stat.op         = r_op;
    assign o_stat.i_lt_cnt   = (r_i < r_count);
    assign o_stat.j_lt_cnt   = (r_j < r_count);
    assign o_stat.j_zero     = (r_j == '0);
    assign o_stat.rd_greater = ($signed(r_rd[63:32]) > $signed(r_k[63:32]));
    assign o_stat.rd_match   = (r_rd[63:32] == r_key);
    assign o_stat.idx_ok     = (XW'(r_idx) < XW'(r_count));
    assign o_stat.out_free   = !r_valid || o_out.ready;

endmodule
`default_nettype wire

>>> tb/sv/tb_record_table_sort_and_search.sv
// Testbench for the record table block: directed and random requests checked against a predictor.
`default_nettype none
module tb_record_table_sort_and_search;
    import rtss_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT = 400000;

    typedef struct {
        t_status            status;
        logic [7:0]         found_index;
        logic signed [31:0] key_out;
        logic [31:0]        payload_out;
        logic [8:0]         entry_total;
    } t_table_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rtss_in_if  req_if ();
    rtss_out_if res_if ();

    record_table_sort_and_search dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (res_if)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the table as the block should hold it.
    logic signed [31:0] shadow_key [DEPTH];
    logic [31:0]        shadow_payload [DEPTH];
    int unsigned        shadow_count;

    t_table_result pending_results[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    function automatic t_table_result predict_table_op(t_op op, logic start_new,
            logic signed [31:0] key, logic [31:0] payload, logic [7:0] index);
        t_table_result r;
        logic signed [31:0] k;
        logic [31:0] p;
        int j;
        r.status = ST_OK;
        r.found_index = '0;
        r.key_out = '0;
        r.payload_out = '0;
        case (op)
            OP_LOAD: begin
                if (start_new) shadow_count = 0;
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_key[shadow_count] = key;
                    shadow_payload[shadow_count] = payload;
                    shadow_count++;
                end
            end
            OP_SORT: begin
                // Stable insertion sort: only strictly greater keys move up.
                for (int i = 1; i < shadow_count; i++) begin
                    k = shadow_key[i];
                    p = shadow_payload[i];
                    j = i;
                    while (j > 0 && shadow_key[j-1] > k) begin
                        shadow_key[j] = shadow_key[j-1];
                        shadow_payload[j] = shadow_payload[j-1];
                        j--;
                    end
                    shadow_key[j] = k;
                    shadow_payload[j] = p;
                end
            end
            OP_FIND: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_key[i] == key) begin
                        r.status = ST_OK;
                        r.found_index = i[7:0];
                        break;
                    end
                end
            end
            default: begin
                if (index < shadow_count) begin
                    r.key_out = shadow_key[index];
                    r.payload_out = shadow_payload[index];
                end else begin
                    r.status = ST_RANGE;
                end
            end
        endcase
        r.entry_total = shadow_count[8:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        error_count++;
    endtask

    // Entered just after a falling edge; returns just after a falling edge.
    task automatic send_request(t_op op, logic start_new, logic signed [31:0] key,
            logic [31:0] payload, logic [7:0] index);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.start_new <= start_new;
        req_if.account_key <= key;
        req_if.payload_bits <= payload;
        req_if.entry_index <= index;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(predict_table_op(op, start_new, key, payload, index));
        @(negedge i_clk);
    endtask

    // Receiver stalls and result checking.
    always @(negedge i_clk) res_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog expired with no transfer");
                $display("Some tests failed");
                $finish;
            end
            if (res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(res_if.status), 32'hffff_ffff);
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.status !== want.status)
                        report_mismatch("status", 32'(res_if.status), 32'(want.status));
                    if (res_if.found_index !== want.found_index)
                        report_mismatch("found_index", 32'(res_if.found_index),
                                        32'(want.found_index));
                    if (res_if.key_out !== want.key_out)
                        report_mismatch("key_out", res_if.key_out, want.key_out);
                    if (res_if.payload_out !== want.payload_out)
                        report_mismatch("payload_out", res_if.payload_out, want.payload_out);
                    if (res_if.entry_total !== want.entry_total)
                        report_mismatch("entry_total", 32'(res_if.entry_total),
                                        32'(want.entry_total));
                end
            end
        end
    end

    task automatic test_empty_table();
        send_request(OP_READ, 1'b0, 32'sd0, 32'h0, 8'd0);
        send_request(OP_FIND, 1'b0, 32'sd0, 32'h0, 8'd0);
        send_request(OP_SORT, 1'b0, 32'sd0, 32'h0, 8'd0);
    endtask

    task automatic test_directed_ops();
        send_request(OP_LOAD, 1'b1, 32'sh7fff_ffff, 32'hffff_ffff, 8'hff);
        send_request(OP_SORT, 1'b1, 32'sd0, 32'h0, 8'd0);
        send_request(OP_LOAD, 1'b0, -32'sh8000_0000, 32'h0, 8'd0);
        send_request(OP_LOAD, 1'b0, 32'sd5, 32'h1111_1111, 8'd0);
        send_request(OP_LOAD, 1'b0, -32'sd1, 32'h2222_2222, 8'd0);
        send_request(OP_LOAD, 1'b0, 32'sd5, 32'h3333_3333, 8'd0);
        send_request(OP_LOAD, 1'b0, 32'sd0, 32'h4444_4444, 8'd0);
        send_request(OP_FIND, 1'b1, 32'sd5, 32'h0, 8'd0);
        send_request(OP_SORT, 1'b0, 32'sd0, 32'h0, 8'd0);
        for (int i = 0; i < 7; i++)
            send_request(OP_READ, i[0], 32'sd0, 32'h0, i[7:0]);
        send_request(OP_READ, 1'b0, 32'sd0, 32'h0, 8'hff);
        send_request(OP_FIND, 1'b0, 32'sd5, 32'h0, 8'd0);
        send_request(OP_FIND, 1'b0, -32'sh8000_0000, 32'h0, 8'd0);
        send_request(OP_FIND, 1'b0, 32'sd7, 32'h0, 8'd0);
    endtask

    // Fill the table in reverse order, overflow it, sort it, then restart it.
    task automatic test_full_table();
        for (int i = 0; i < DEPTH; i++)
            send_request(OP_LOAD, i == 0, 32'(DEPTH - i) - 32'sd100, 32'(i), 8'd0);
        send_request(OP_LOAD, 1'b0, 32'sd1, 32'h1, 8'd0);
        send_request(OP_SORT, 1'b0, 32'sd0, 32'h0, 8'd0);
        send_request(OP_READ, 1'b0, 32'sd0, 32'h0, 8'd0);
        send_request(OP_READ, 1'b0, 32'sd0, 32'h0, 8'hff);
        send_request(OP_FIND, 1'b0, 32'sd155, 32'h0, 8'd0);
        send_request(OP_LOAD, 1'b1, 32'sd9, 32'h9, 8'd0);
    endtask

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'sh7fff_ffff : -32'sh8000_0000;
            default: return 32'($urandom_range(8)) - 32'sd4;
        endcase
    endfunction

    task automatic test_random_sessions(int item_goal);
        int sent;
        int n;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(9) == 0) begin
                // Noise: any operation with any fields.
                send_request(t_op'($urandom_range(3)), 1'($urandom_range(1)), $urandom(),
                             $urandom(), 8'($urandom_range(255)));
                sent++;
            end else begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_request(OP_LOAD, i == 0 || $urandom_range(19) == 0, pick_key(),
                                 $urandom(), 8'($urandom_range(255)));
                if ($urandom_range(3) != 0)
                    send_request(OP_SORT, 1'($urandom_range(1)), $urandom(), $urandom(),
                                 8'($urandom_range(255)));
                for (int i = 0; i < 4; i++) begin
                    send_request(OP_FIND, 1'($urandom_range(1)), pick_key(), $urandom(),
                                 8'($urandom_range(255)));
                    send_request(OP_READ, 1'($urandom_range(1)), $urandom(), $urandom(),
                                 8'($urandom_range(3) == 0 ? $urandom_range(255)
                                                           : $urandom_range(n + 1)));
                end
                sent += n + 9;
            end
        end
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.operation = OP_LOAD;
        req_if.start_new = 1'b0;
        req_if.account_key = '0;
        req_if.payload_bits = '0;
        req_if.entry_index = '0;
        res_if.ready = 1'b0;
        shadow_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_directed_ops();
        test_full_table();
        send_idle_pct = 24;
        recv_idle_pct = 62;
        test_random_sessions(205);
        send_idle_pct = 62;
        recv_idle_pct = 24;
        test_random_sessions(205);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sessions(205);
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
rtl/rtss_pkg.sv
rtl/rtss_if.sv
rtl/rtss_ctrl.sv
rtl/rtss_dp.sv
rtl/record_table_sort_and_search.sv
tb/sv/tb_record_table_sort_and_search.sv
